// ===== src/hlp_pkg.sv =====
package hlp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_THRESHOLD_LOW  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_HIGH = 2'd1;
    localparam logic [1:0] CFG_SOURCE_DEPTH   = 2'd2;

    localparam logic [7:0] THRESHOLD_LOW_RESET  = 8'd0;
    localparam logic [7:0] THRESHOLD_HIGH_RESET = 8'd128;
    localparam logic [4:0] SOURCE_DEPTH_RESET   = 5'd16;
    localparam logic [4:0] DEPTH_MIN            = 5'd1;
    localparam logic [4:0] DEPTH_MAX            = 5'd16;
    localparam logic [4:0] DEPTH_BYTE           = 5'd8;

    localparam logic [7:0] FIRST_BIT_MASK = 8'h80;
    localparam logic [2:0] LAST_BIT_POS   = 3'd7;

    typedef struct packed {
        logic [15:0] sample;
        logic        end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
        logic       threshold_error;
    } out_item_t;

    typedef enum logic [1:0] {
        CLS_BLACK,
        CLS_WHITE,
        CLS_HOLD
    } cls_t;

    typedef struct packed {
        cls_t cls;
        logic eol;
        logic err;
    } queue_entry_t;

endpackage

// ===== src/hlp_front.sv =====
module hlp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  in_valid,
    input  hlp_pkg::in_item_t     in_item,
    input  logic                  queue_full,
    output logic                  push,
    output hlp_pkg::queue_entry_t push_entry
);
    import hlp_pkg::*;

    logic [7:0]  threshold_low_reg;
    logic [7:0]  threshold_high_reg;
    logic [4:0]  source_depth_reg;
    logic [4:0]  depth;
    logic [15:0] scaled_low;
    logic [15:0] scaled_high;
    logic        inverted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_low_reg  <= THRESHOLD_LOW_RESET;
            threshold_high_reg <= THRESHOLD_HIGH_RESET;
            source_depth_reg   <= SOURCE_DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_THRESHOLD_LOW:  threshold_low_reg  <= cfg_data;
                CFG_THRESHOLD_HIGH: threshold_high_reg <= cfg_data;
                CFG_SOURCE_DEPTH:   source_depth_reg   <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (source_depth_reg < DEPTH_MIN)
            depth = DEPTH_MIN;
        else if (source_depth_reg > DEPTH_MAX)
            depth = DEPTH_MAX;
        else
            depth = source_depth_reg;

        if (depth >= DEPTH_BYTE)
        begin
            scaled_low  = {8'd0, threshold_low_reg}  << (depth - DEPTH_BYTE);
            scaled_high = {8'd0, threshold_high_reg} << (depth - DEPTH_BYTE);
        end
        else
        begin
            scaled_low  = {8'd0, threshold_low_reg}  >> (DEPTH_BYTE - depth);
            scaled_high = {8'd0, threshold_high_reg} >> (DEPTH_BYTE - depth);
        end
    end

    assign inverted = threshold_low_reg > threshold_high_reg;

    // With inverted thresholds only the end-of-line item has any effect.
    always_comb
    begin
        push_entry.eol = in_item.end_of_line;
        push_entry.err = inverted;
        if (in_item.sample >= scaled_high)
            push_entry.cls = CLS_WHITE;
        else if (in_item.sample <= scaled_low)
            push_entry.cls = CLS_BLACK;
        else
            push_entry.cls = CLS_HOLD;
        push = in_valid && !queue_full && (!inverted || in_item.end_of_line);
    end

endmodule

// ===== src/hlp_queue.sv =====
module hlp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hlp_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output hlp_pkg::queue_entry_t pop_entry,
    output logic                  full,
    output logic                  not_empty
);
    import hlp_pkg::*;

    queue_entry_t          entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CW'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    assign pop_entry = entries[rd_ptr_reg];
    assign full      = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;

endmodule

// ===== src/hlp_back.sv =====
module hlp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    input  hlp_pkg::queue_entry_t pop_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hlp_pkg::out_item_t    out_item
);
    import hlp_pkg::*;

    logic       previous_white_reg;
    logic       previous_white_next;
    logic [2:0] bit_position_reg;
    logic [2:0] bit_position_next;
    logic [7:0] partial_byte_reg;
    logic [7:0] partial_byte_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       white;
    logic [7:0] merged;

    assign pop = not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (pop_entry.cls)
            CLS_WHITE: white = 1'b1;
            CLS_BLACK: white = 1'b0;
            default:   white = previous_white_reg;
        endcase
        merged = partial_byte_reg | (white ? (FIRST_BIT_MASK >> bit_position_reg) : 8'd0);

        previous_white_next = previous_white_reg;
        bit_position_next   = bit_position_reg;
        partial_byte_next   = partial_byte_reg;
        out_item_next       = out_item_reg;
        out_valid_next      = out_valid_reg && out_stall;

        if (pop)
        begin
            if (pop_entry.err)
            begin
                previous_white_next           = 1'b0;
                bit_position_next             = '0;
                partial_byte_next             = '0;
                out_valid_next                = 1'b1;
                out_item_next.packed_byte     = '0;
                out_item_next.last_byte       = 1'b1;
                out_item_next.threshold_error = 1'b1;
            end
            else if (bit_position_reg == LAST_BIT_POS || pop_entry.eol)
            begin
                previous_white_next           = pop_entry.eol ? 1'b0 : white;
                bit_position_next             = '0;
                partial_byte_next             = '0;
                out_valid_next                = 1'b1;
                out_item_next.packed_byte     = merged;
                out_item_next.last_byte       = pop_entry.eol;
                out_item_next.threshold_error = 1'b0;
            end
            else
            begin
                previous_white_next = white;
                bit_position_next   = bit_position_reg + 3'd1;
                partial_byte_next   = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_white_reg <= 1'b0;
            bit_position_reg   <= '0;
            partial_byte_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            previous_white_reg <= previous_white_next;
            bit_position_reg   <= bit_position_next;
            partial_byte_reg   <= partial_byte_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== src/hysteresis_lineart_packer_core.sv =====
// Hysteresis line-art packer.
// Gray samples of a scan line enter on the input channel (in_valid, in_stall,
// in_item), one item per sample, with end_of_line set on the final sample.
// Packed line-art bytes leave on the output channel (out_valid, out_stall,
// out_item): one byte per eight samples, and a zero-padded byte marked last
// at the end of each line. With the low threshold above the high one, only
// the end-of-line sample yields an item, a zero byte with threshold_error set.
// Thresholds and source depth are written through cfg_write, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. Throughput is one sample per cycle while
// in_stall is low. The edge that accepts the sample which completes a result
// writes it into the four-entry queue between the classifier and the packer;
// the packer then pops it and loads its output register when not stalled.
// Reset restores the thresholds to 0 and 128 and the depth to 16, empties the
// queue and clears the packer. While the receiver stalls, the output item is
// held; the queue absorbs up to four more samples before in_stall rises.
module hysteresis_lineart_packer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  hlp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output hlp_pkg::out_item_t out_item
);
    import hlp_pkg::*;

    logic         push;
    logic         pop;
    logic         queue_full;
    logic         queue_not_empty;
    queue_entry_t push_entry;
    queue_entry_t pop_entry;

    hlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    hlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (queue_full),
        .not_empty  (queue_not_empty)
    );

    hlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (queue_not_empty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

    assign in_stall = queue_full;

endmodule

// ===== src/hlp_checker.sv =====
module hlp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input hlp_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input hlp_pkg::out_item_t out_item
);
    import hlp_pkg::*;

    // A stalled output item stays in place until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // The error item closes a line and carries no bits.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.threshold_error |->
            out_item.last_byte && out_item.packed_byte == 8'd0)
        else $error("error item is not a zero last byte");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // The input side is never held off unless the output side has been stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without an output stall");

endmodule

bind hysteresis_lineart_packer_core hlp_checker u_hlp_checker (.*);
